// ===== rtl/htq_pkg.sv =====
// shared constants for the heightmap triangle height query block
package htq_pkg;

   // action codes of a request word
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_CLAMP = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   // register indexes of the csr port
   localparam logic [1:0] CSR_MAP_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_INV_SCALE_X = 2'd2;
   localparam logic [1:0] CSR_INV_SCALE_Z = 2'd3;

   // fixed field widths
   localparam int POS_W   = 24;
   localparam int DIM_W   = 11;
   localparam int SCALE_W = 17;
   localparam int ADDR_W  = 17;
   localparam int CELL_W  = 8;
   localparam int SCALE_SHIFT = 16;

   // saturation bounds of a 24-bit result
   localparam int SAT_MAX = 8388607;
   localparam int SAT_MIN = -8388608;

endpackage

// ===== rtl/heightmap_triangle_height_query.sv =====
// heightmap triangle height query top level
// one word per cycle unless the response stalls; a query reads three corners from two memories
// writes land in the memories in order with the corner reads, so no forwarding is needed
// reset clears pipeline valids and presets csrs; heightmap contents are undefined until written
module heightmap_triangle_height_query
   import htq_pkg::*;
#(
   parameter int MAX_CELLS = 131072,
   parameter int FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_action,
   input  logic [ADDR_W-1:0]        req_cell_address,
   input  logic [CELL_W-1:0]        req_cell_value,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  logic                     req_reverse_diagonal,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_foot_offset,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [POS_W-1:0]  rsp_terrain_height,
   output logic                     rsp_out_of_bounds,
   output logic                     rsp_collided,
   output logic signed [POS_W-1:0]  rsp_clamped_y,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [SCALE_W-1:0]       csr_wdata
);

   localparam int AW = $clog2(MAX_CELLS);
   localparam int F  = FRAC_BITS;
   localparam int TW = F + 15;
   localparam int VW = TW + F + 2;
   localparam int HW = VW - F;
   localparam logic signed [HW:0] SAT_HI = (HW+1)'(SAT_MAX);
   localparam logic signed [HW:0] SAT_LO = (HW+1)'(SAT_MIN);

   // csr registers
   logic [DIM_W-1:0]   map_width_ff, map_height_ff;
   logic [SCALE_W-1:0] inv_x_ff, inv_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= DIM_W'(257);
         map_height_ff <= DIM_W'(257);
         inv_x_ff      <= SCALE_W'(8192);
         inv_z_ff      <= SCALE_W'(8192);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:   map_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_MAP_HEIGHT:  map_height_ff <= csr_wdata[DIM_W-1:0];
            CSR_INV_SCALE_X: inv_x_ff      <= csr_wdata;
            CSR_INV_SCALE_Z: inv_z_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage valids and load enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, rsp_valid_ff;
   logic ld1, ld2, ld3, ld4, ld5, ld6, ld_o;

   assign ld_o = !rsp_valid_ff || rsp_ready;
   assign ld6  = !v6_ff || ld_o;
   assign ld5  = !v5_ff || ld6;
   assign ld4  = !v4_ff || ld5;
   assign ld3  = !v3_ff || ld4;
   assign ld2  = !v2_ff || ld3;
   assign ld1  = !v1_ff || ld2;
   assign req_ready = ld1;

   logic s3_result;
   logic [1:0] act3_ff;
   assign s3_result = (act3_ff == ACT_QUERY) || (act3_ff == ACT_CLAMP);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1)  v1_ff <= req_valid;
         if (ld2)  v2_ff <= v1_ff;
         if (ld3)  v3_ff <= v2_ff;
         if (ld4)  v4_ff <= v3_ff && s3_result;
         if (ld5)  v5_ff <= v4_ff;
         if (ld6)  v6_ff <= v5_ff;
         if (ld_o) rsp_valid_ff <= v6_ff;
      end
   end

   // stage 1: captured request word
   logic [1:0]              act1_ff;
   logic [ADDR_W-1:0]       addr1_ff;
   logic [CELL_W-1:0]       val1_ff;
   logic signed [POS_W-1:0] px1_ff, pz1_ff, py1_ff, foot1_ff;
   logic                    rev1_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         act1_ff  <= req_action;
         addr1_ff <= req_cell_address;
         val1_ff  <= req_cell_value;
         px1_ff   <= req_pos_x;
         pz1_ff   <= req_pos_z;
         py1_ff   <= req_pos_y;
         foot1_ff <= req_foot_offset;
         rev1_ff  <= req_reverse_diagonal;
      end
   end

   // scale world position to grid units
   logic [POS_W+SCALE_W-1:0] mx1, mz1;
   assign mx1 = (POS_W+SCALE_W)'(px1_ff[POS_W-2:0]) * (POS_W+SCALE_W)'(inv_x_ff);
   assign mz1 = (POS_W+SCALE_W)'(pz1_ff[POS_W-2:0]) * (POS_W+SCALE_W)'(inv_z_ff);

   logic [1:0]              act2_ff;
   logic [ADDR_W-1:0]       addr2_ff;
   logic [CELL_W-1:0]       val2_ff;
   logic                    neg2_ff, rev2_ff;
   logic [POS_W-1:0]        gx2_ff, gz2_ff;
   logic signed [POS_W-1:0] py2_ff, foot2_ff;

   always_ff @(posedge clock) begin
      if (ld2) begin
         act2_ff  <= act1_ff;
         addr2_ff <= addr1_ff;
         val2_ff  <= val1_ff;
         neg2_ff  <= px1_ff[POS_W-1] || pz1_ff[POS_W-1];
         rev2_ff  <= rev1_ff;
         gx2_ff   <= mx1[SCALE_SHIFT +: POS_W];
         gz2_ff   <= mz1[SCALE_SHIFT +: POS_W];
         py2_ff   <= py1_ff;
         foot2_ff <= foot1_ff;
      end
   end

   // stage 2: cell, fraction, bounds, edge direction, row offset
   logic [POS_W-1:0] ixf2, izf2;
   logic [31:0]      xlim2, zlim2;
   logic             oob2, axn2, azn2, rev2;
   assign ixf2  = gx2_ff >> F;
   assign izf2  = gz2_ff >> F;
   assign oob2  = neg2_ff || (ixf2 >= POS_W'(map_width_ff)) || (izf2 >= POS_W'(map_height_ff));
   assign xlim2 = 32'(map_width_ff - DIM_W'(1)) << F;
   assign zlim2 = 32'(map_height_ff - DIM_W'(1)) << F;
   assign axn2  = !(32'(gx2_ff) < xlim2);
   assign azn2  = !(32'(gz2_ff) < zlim2);
   assign rev2  = (act2_ff == ACT_CLAMP) ? gz2_ff[F] : rev2_ff;

   logic [ADDR_W-1:0]       addr3_ff;
   logic [CELL_W-1:0]       val3_ff;
   logic                    oob3_ff, axn3_ff, azn3_ff, rev3_ff;
   logic [DIM_W-1:0]        ix3_ff;
   logic [2*DIM_W-1:0]      izw3_ff;
   logic [F-1:0]            fx3_ff, fz3_ff;
   logic signed [POS_W-1:0] py3_ff, foot3_ff;

   always_ff @(posedge clock) begin
      if (ld3) begin
         act3_ff  <= act2_ff;
         addr3_ff <= addr2_ff;
         val3_ff  <= val2_ff;
         oob3_ff  <= oob2;
         axn3_ff  <= axn2;
         azn3_ff  <= azn2;
         rev3_ff  <= rev2;
         ix3_ff   <= ixf2[DIM_W-1:0];
         izw3_ff  <= izf2[DIM_W-1:0] * map_width_ff;
         fx3_ff   <= gx2_ff[F-1:0];
         fz3_ff   <= gz2_ff[F-1:0];
         py3_ff   <= py2_ff;
         foot3_ff <= foot2_ff;
      end
   end

   // stage 3: corner addresses and port selection
   logic [POS_W-1:0] a00, a01, a10, a11, p0, p1, p2;
   logic             sel3;
   assign a00  = POS_W'(ix3_ff) + POS_W'(izw3_ff);
   assign a01  = azn3_ff ? a00 - POS_W'(map_width_ff) : a00 + POS_W'(map_width_ff);
   assign a10  = axn3_ff ? a00 - POS_W'(1) : a00 + POS_W'(1);
   assign a11  = axn3_ff ? a01 - POS_W'(1) : a01 + POS_W'(1);
   assign sel3 = rev3_ff ? (fx3_ff < fz3_ff)
                         : ((F+1)'(fx3_ff) + (F+1)'(fz3_ff) < (F+1)'(1 << F));
   assign p0 = rev3_ff ? a00 : a10;
   assign p1 = rev3_ff ? a11 : a01;
   assign p2 = rev3_ff ? (sel3 ? a01 : a10) : (sel3 ? a00 : a11);

   // write side of the heightmap
   logic [POS_W-1:0] waddr3;
   logic             wen3;
   assign waddr3 = POS_W'(addr3_ff);
   assign wen3   = ld4 && v3_ff && (act3_ff == ACT_WRITE) && (waddr3 < POS_W'(MAX_CELLS));

   // two copies of the heightmap, the first read at two addresses and the second at one
   logic [CELL_W-1:0] mem_a [MAX_CELLS];
   logic [CELL_W-1:0] mem_b [MAX_CELLS];
   logic [CELL_W-1:0] rd0_ff, rd1_ff, rd2_ff;

   always_ff @(posedge clock) begin
      if (wen3) mem_a[waddr3[AW-1:0]] <= val3_ff;
      if (ld4) begin
         rd0_ff <= mem_a[p0[AW-1:0]];
         rd1_ff <= mem_a[p1[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wen3) mem_b[waddr3[AW-1:0]] <= val3_ff;
      if (ld4) rd2_ff <= mem_b[p2[AW-1:0]];
   end

   logic                    in0_ff, in1_ff, in2_ff, rev4_ff, sel4_ff, oob4_ff;
   logic [1:0]              act4_ff;
   logic [F-1:0]            fx4_ff, fz4_ff;
   logic signed [POS_W-1:0] py4_ff, foot4_ff;

   always_ff @(posedge clock) begin
      if (ld4) begin
         in0_ff   <= p0 < POS_W'(MAX_CELLS);
         in1_ff   <= p1 < POS_W'(MAX_CELLS);
         in2_ff   <= p2 < POS_W'(MAX_CELLS);
         rev4_ff  <= rev3_ff;
         sel4_ff  <= sel3;
         oob4_ff  <= oob3_ff;
         act4_ff  <= act3_ff;
         fx4_ff   <= fx3_ff;
         fz4_ff   <= fz3_ff;
         py4_ff   <= py3_ff;
         foot4_ff <= foot3_ff;
      end
   end

   // stage 4: corners, extrapolated fourth corner, interpolation along x
   logic signed [11:0] d0, d1, d2, tl, tr, bl, br;
   assign d0 = in0_ff ? signed'({3'b0, rd0_ff, 1'b0}) : 12'sd0;
   assign d1 = in1_ff ? signed'({3'b0, rd1_ff, 1'b0}) : 12'sd0;
   assign d2 = in2_ff ? signed'({3'b0, rd2_ff, 1'b0}) : 12'sd0;

   always_comb begin
      if (rev4_ff) begin
         tl = d0;
         br = d1;
         if (sel4_ff) begin
            bl = d2;
            tr = tl + (br - bl);
         end else begin
            tr = d2;
            bl = tl + (br - tr);
         end
      end else begin
         tr = d0;
         bl = d1;
         if (sel4_ff) begin
            tl = d2;
            br = bl + (tr - tl);
         end else begin
            br = d2;
            tl = tr + (bl - br);
         end
      end
   end

   logic signed [TW-1:0] top4, bot4;
   logic signed [F:0]    fxs4;
   assign fxs4 = signed'({1'b0, fx4_ff});
   assign top4 = (TW'(tl) <<< F) + TW'(TW'(tr - tl) * TW'(fxs4));
   assign bot4 = (TW'(bl) <<< F) + TW'(TW'(br - bl) * TW'(fxs4));

   logic signed [TW-1:0]    top5_ff, bot5_ff;
   logic                    oob5_ff;
   logic [1:0]              act5_ff;
   logic [F-1:0]            fz5_ff;
   logic signed [POS_W-1:0] py5_ff, foot5_ff;

   always_ff @(posedge clock) begin
      if (ld5) begin
         top5_ff  <= top4;
         bot5_ff  <= bot4;
         oob5_ff  <= oob4_ff;
         act5_ff  <= act4_ff;
         fz5_ff   <= fz4_ff;
         py5_ff   <= py4_ff;
         foot5_ff <= foot4_ff;
      end
   end

   // stage 5: interpolation along z, floor back to Q.F
   logic signed [VW-1:0] v5;
   logic signed [F:0]    fzs5;
   assign fzs5 = signed'({1'b0, fz5_ff});
   assign v5 = (VW'(top5_ff) <<< F) + VW'(VW'(bot5_ff - top5_ff) * VW'(fzs5));

   logic signed [HW-1:0]    h6_ff;
   logic                    oob6_ff;
   logic [1:0]              act6_ff;
   logic signed [POS_W-1:0] py6_ff, foot6_ff;

   always_ff @(posedge clock) begin
      if (ld6) begin
         h6_ff    <= oob5_ff ? '0 : v5[VW-1:F];
         oob6_ff  <= oob5_ff;
         act6_ff  <= act5_ff;
         py6_ff   <= py5_ff;
         foot6_ff <= foot5_ff;
      end
   end

   // stage 6: saturation and ground clamp
   logic signed [HW:0]      hx6, tgt6, yx6;
   logic signed [POS_W-1:0] hs6, ts6, yout6;
   logic                    hit6;
   assign hx6  = (HW+1)'(h6_ff);
   assign tgt6 = hx6 - (HW+1)'(foot6_ff);
   assign yx6  = (HW+1)'(py6_ff);
   assign hs6  = (hx6 > SAT_HI) ? POS_W'(SAT_MAX) :
                 (hx6 < SAT_LO) ? POS_W'(SAT_MIN) : hx6[POS_W-1:0];
   assign ts6  = (tgt6 > SAT_HI) ? POS_W'(SAT_MAX) :
                 (tgt6 < SAT_LO) ? POS_W'(SAT_MIN) : tgt6[POS_W-1:0];
   assign hit6  = (act6_ff == ACT_CLAMP) && (yx6 < tgt6);
   assign yout6 = (act6_ff != ACT_CLAMP) ? '0 : (hit6 ? ts6 : py6_ff);

   // response register
   logic signed [POS_W-1:0] height_o_ff, clamped_o_ff;
   logic                    oob_o_ff, hit_o_ff;

   always_ff @(posedge clock) begin
      if (ld_o) begin
         height_o_ff  <= hs6;
         oob_o_ff     <= oob6_ff;
         hit_o_ff     <= hit6;
         clamped_o_ff <= yout6;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_terrain_height = height_o_ff;
   assign rsp_out_of_bounds  = oob_o_ff;
   assign rsp_collided       = hit_o_ff;
   assign rsp_clamped_y      = clamped_o_ff;

   // an out-of-bounds word always reports zero height
   a_oob_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_bounds |-> rsp_terrain_height == '0)
      else $error("out-of-bounds response with nonzero height");

   // an empty front stage never refuses a request
   a_front_open: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_ready)
      else $error("request refused with empty front stage");

   // a response that is not taken stays on the port
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_terrain_height))
      else $error("response dropped while stalled");

endmodule

// ===== tb/heightmap_triangle_height_query_checker.sv =====
`timescale 1ns / 1ps
// response checker with a built-in height predictor for the height query block
module heightmap_triangle_height_query_checker
   import htq_pkg::*;
#(
   parameter int MAX_CELLS = 131072,
   parameter int FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [1:0]               req_action,
   input  logic [ADDR_W-1:0]        req_cell_address,
   input  logic [CELL_W-1:0]        req_cell_value,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  logic                     req_reverse_diagonal,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_foot_offset,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [POS_W-1:0]  rsp_terrain_height,
   input  logic                     rsp_out_of_bounds,
   input  logic                     rsp_collided,
   input  logic signed [POS_W-1:0]  rsp_clamped_y,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [SCALE_W-1:0]       csr_wdata,
   output int                       mismatches,
   output int                       outstanding
);

   typedef struct {
      logic signed [POS_W-1:0] height;
      logic                    oob;
      logic                    hit;
      logic signed [POS_W-1:0] y;
   } height_result_t;

   logic [CELL_W-1:0] height_map [MAX_CELLS];
   longint            cols, rows, scale_x, scale_z;
   height_result_t    expected_heights [$];

   // saturate to the 24-bit signed range
   function automatic longint clip24(longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < SAT_MIN) return SAT_MIN;
      return v;
   endfunction

   // corner height, zero outside the store
   function automatic longint cell_height(longint cx, longint cz);
      longint a;
      a = cx + cz * cols;
      if (a < 0 || a >= MAX_CELLS) return 0;
      return longint'(height_map[a]) * 2;
   endfunction

   // full height prediction for a query or ground clamp word
   function automatic height_result_t predict_height(logic [1:0] act, longint px, longint pz,
                                                     logic rev_in, longint py, longint foot);
      height_result_t r;
      longint gx, gz, ix, iz, fx, fz, ax, az, one, tl, tr, bl, br, top, bot, h, target;
      logic rev;
      r = '{default: '0};
      one = longint'(1) << FRAC_BITS;
      h = 0;
      rev = rev_in;
      // ground clamp takes the split from grid row parity
      if (act == ACT_CLAMP)
         rev = (pz >= 0) ? ((((pz * scale_z) >> SCALE_SHIFT) >> FRAC_BITS) & 1) : 1'b0;
      r.oob = 1'b1;
      if (px >= 0 && pz >= 0) begin
         gx = (px * scale_x) >> SCALE_SHIFT;
         gz = (pz * scale_z) >> SCALE_SHIFT;
         ix = gx >> FRAC_BITS;
         iz = gz >> FRAC_BITS;
         if (ix < cols && iz < rows) begin
            r.oob = 1'b0;
            fx = gx & (one - 1);
            fz = gz & (one - 1);
            // neighbor steps back on the last column or row
            ax = (gx < ((cols - 1) << FRAC_BITS)) ? 1 : -1;
            az = (gz < ((rows - 1) << FRAC_BITS)) ? 1 : -1;
            if (rev) begin
               tl = cell_height(ix, iz);
               br = cell_height(ix + ax, iz + az);
               if (fx < fz) begin
                  bl = cell_height(ix, iz + az);
                  tr = tl + (br - bl);
               end else begin
                  tr = cell_height(ix + ax, iz);
                  bl = tl + (br - tr);
               end
            end else begin
               tr = cell_height(ix + ax, iz);
               bl = cell_height(ix, iz + az);
               if (fx + fz < one) begin
                  tl = cell_height(ix, iz);
                  br = bl + (tr - tl);
               end else begin
                  br = cell_height(ix + ax, iz + az);
                  tl = tr + (bl - br);
               end
            end
            top = tl * one + (tr - tl) * fx;
            bot = bl * one + (br - bl) * fx;
            h = (top * one + (bot - top) * fz) >>> FRAC_BITS;
         end
      end
      r.height = clip24(h);
      // ground clamp compares against the unsaturated target
      if (act == ACT_CLAMP) begin
         target = h - foot;
         if (py < target) begin
            r.hit = 1'b1;
            r.y = clip24(target);
         end else begin
            r.y = py;
         end
      end
      return r;
   endfunction

   assign outstanding = expected_heights.size();

   // track config, predict accepted words, compare responses
   always @(posedge clock) begin
      height_result_t want;
      if (reset) begin
         cols <= 257;
         rows <= 257;
         scale_x <= 8192;
         scale_z <= 8192;
         mismatches <= mismatches;
         expected_heights.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MAP_WIDTH:   cols <= csr_wdata[DIM_W-1:0];
               CSR_MAP_HEIGHT:  rows <= csr_wdata[DIM_W-1:0];
               CSR_INV_SCALE_X: scale_x <= csr_wdata;
               CSR_INV_SCALE_Z: scale_z <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_action)
               ACT_WRITE: if (req_cell_address < MAX_CELLS)
                  height_map[req_cell_address] = req_cell_value;
               ACT_QUERY, ACT_CLAMP:
                  expected_heights.push_back(predict_height(req_action, req_pos_x, req_pos_z,
                     req_reverse_diagonal, req_pos_y, req_foot_offset));
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_heights.size() == 0) begin
               $error("response word with no query waiting");
               mismatches <= mismatches + 1;
            end else begin
               want = expected_heights.pop_front();
               if (rsp_terrain_height !== want.height) begin
                  $error("terrain_height expected %0d got %0d", want.height, rsp_terrain_height);
                  mismatches <= mismatches + 1;
               end
               if (rsp_out_of_bounds !== want.oob) begin
                  $error("out_of_bounds expected %0d got %0d", want.oob, rsp_out_of_bounds);
                  mismatches <= mismatches + 1;
               end
               if (rsp_collided !== want.hit) begin
                  $error("collided expected %0d got %0d", want.hit, rsp_collided);
                  mismatches <= mismatches + 1;
               end
               if (rsp_clamped_y !== want.y) begin
                  $error("clamped_y expected %0d got %0d", want.y, rsp_clamped_y);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

   initial mismatches = 0;

endmodule

// ===== tb/heightmap_triangle_height_query_test.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the heightmap triangle height query block
module heightmap_triangle_height_query_test;
   import htq_pkg::*;

   localparam int CELLS = 131072;
   localparam int LIMIT = 3000000;

   logic                    clock;
   logic                    reset;
   logic                    req_valid, req_ready;
   logic [1:0]              req_action;
   logic [ADDR_W-1:0]       req_cell_address;
   logic [CELL_W-1:0]       req_cell_value;
   logic signed [POS_W-1:0] req_pos_x, req_pos_z, req_pos_y, req_foot_offset;
   logic                    req_reverse_diagonal;
   logic                    rsp_valid, rsp_ready;
   logic signed [POS_W-1:0] rsp_terrain_height, rsp_clamped_y;
   logic                    rsp_out_of_bounds, rsp_collided;
   logic                    csr_we;
   logic [1:0]              csr_index;
   logic [SCALE_W-1:0]      csr_wdata;
   int                      mismatches, outstanding;
   int                      cycles;
   bit                      long_hold;
   longint                  cur_cols, cur_rows, cur_sx, cur_sz;

   heightmap_triangle_height_query DUT (.*);

   heightmap_triangle_height_query_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side: random stalls plus one long hold-off on request
   initial begin
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // offer one word and wait for acceptance; gap of idle cycles afterwards
   task automatic send_word(logic [1:0] act, logic [ADDR_W-1:0] addr, logic [CELL_W-1:0] val,
                            logic [23:0] px, logic [23:0] pz, logic rev,
                            logic [23:0] py, logic [23:0] foot, int gap);
      req_valid <= 1;
      req_action <= act;
      req_cell_address <= addr;
      req_cell_value <= val;
      req_pos_x <= px;
      req_pos_z <= pz;
      req_reverse_diagonal <= rev;
      req_pos_y <= py;
      req_foot_offset <= foot;
      do @(posedge clock); while (!req_ready);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      do @(posedge clock); while (outstanding != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_reg(logic [1:0] idx, longint val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_MAP_WIDTH:   cur_cols = val;
         CSR_MAP_HEIGHT:  cur_rows = val;
         CSR_INV_SCALE_X: cur_sx = val;
         default:         cur_sz = val;
      endcase
   endtask

   // position mostly inside the map, sometimes anywhere
   function automatic logic [23:0] pick_pos(longint scale, longint dim);
      longint lim;
      if ($urandom_range(0, 7) == 0 || scale == 0) return $urandom;
      lim = ((dim + 1) << 24) / scale;
      if (lim > SAT_MAX) lim = SAT_MAX;
      return $urandom_range(0, lim);
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 2) != 0) return 0;
      return ($urandom_range(0, 12) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   task automatic random_words(int count);
      int k;
      logic [1:0] act;
      for (k = 0; k < count; k++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: act = ACT_WRITE;
            4:          act = ACT_NONE;
            5, 6, 7, 8, 9, 10, 11: act = ACT_QUERY;
            default:    act = ACT_CLAMP;
         endcase
         send_word(act, $urandom, $urandom, pick_pos(cur_sx, cur_cols), pick_pos(cur_sz, cur_rows),
                   $urandom, $urandom, ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1024)),
                   pick_gap());
      end
   endtask

   initial begin
      int i;
      long_hold = 0;
      cycles = 0;
      req_valid = 0;
      req_action = ACT_NONE;
      req_cell_address = 0;
      req_cell_value = 0;
      req_pos_x = 0;
      req_pos_z = 0;
      req_reverse_diagonal = 0;
      req_pos_y = 0;
      req_foot_offset = 0;
      csr_we = 0;
      csr_index = CSR_MAP_WIDTH;
      csr_wdata = 0;
      cur_cols = 257;
      cur_rows = 257;
      cur_sx = 8192;
      cur_sz = 8192;
      reset = 1;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // load every cell so no corner read hits unwritten storage
      for (i = 0; i < CELLS; i++)
         send_word(ACT_WRITE, i, $urandom, 0, 0, 0, 0, 0, 0);

      // directed words at the default map size
      send_word(ACT_WRITE, CELLS - 1, 8'hff, 0, 0, 0, 0, 0, 0);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
      send_word(ACT_QUERY, 0, 0, 0, 0, 1, 0, 0, 1);
      send_word(ACT_QUERY, 0, 0, 24'h7fffff, 24'h7fffff, 0, 0, 0, 0);
      send_word(ACT_QUERY, 0, 0, 24'h800000, 100, 0, 0, 0, 0);
      send_word(ACT_QUERY, 0, 0, 100, 24'hffffff, 1, 0, 0, 0);
      // last column and row of a 257 wide map
      send_word(ACT_QUERY, 0, 0, 524288 + 1000, 524288 + 300, 0, 0, 0, 0);
      send_word(ACT_QUERY, 0, 0, 524288 + 300, 524288 + 1000, 1, 0, 0, 2);
      send_word(ACT_QUERY, 0, 0, 526335, 300000, 1, 0, 0, 0);
      send_word(ACT_NONE, 0, 0, 1000, 1000, 0, 0, 0, 0);
      // clamp: raised, kept, saturated, out of bounds, odd row
      send_word(ACT_CLAMP, 0, 0, 5000, 5000, 0, 24'h800000, 0, 0);
      send_word(ACT_CLAMP, 0, 0, 5000, 5000, 0, 24'h7fffff, 0, 0);
      send_word(ACT_CLAMP, 0, 0, 5000, 2048 + 700, 0, 0, 24'h800000, 0);
      send_word(ACT_CLAMP, 0, 0, 24'h800000, 5000, 0, 0, 24'h7fffff, 3);
      send_word(ACT_CLAMP, 0, 0, 9000, 24'h800000, 0, 24'h800000, 24'h7fffff, 0);
      send_word(ACT_CLAMP, 0, 0, 3000, 2048 * 5 + 100, 0, 100, 24'hfffff0, 0);
      send_word(ACT_WRITE, 3, 8'h00, 0, 0, 0, 0, 0, 0);
      send_word(ACT_QUERY, 0, 0, 4096, 0, 0, 0, 0, 0);

      // sender pauses until every response is back
      drain();
      long_hold = 1;
      random_words(80);

      // smallest map, full scale
      drain();
      set_reg(CSR_MAP_WIDTH, 2);
      set_reg(CSR_MAP_HEIGHT, 2);
      set_reg(CSR_INV_SCALE_X, 65536);
      set_reg(CSR_INV_SCALE_Z, 65536);
      send_word(ACT_QUERY, 0, 0, 511, 511, 0, 0, 0, 0);
      send_word(ACT_QUERY, 0, 0, 300, 100, 1, 0, 0, 0);
      random_words(70);

      // largest map, zero x scale
      drain();
      set_reg(CSR_MAP_WIDTH, 1024);
      set_reg(CSR_MAP_HEIGHT, 1024);
      set_reg(CSR_INV_SCALE_X, 0);
      set_reg(CSR_INV_SCALE_Z, 40000);
      random_words(80);

      // odd sizes, zero z scale
      drain();
      set_reg(CSR_MAP_WIDTH, 37);
      set_reg(CSR_MAP_HEIGHT, 511);
      set_reg(CSR_INV_SCALE_X, 1234);
      set_reg(CSR_INV_SCALE_Z, 0);
      random_words(70);

      // random settings
      drain();
      set_reg(CSR_MAP_WIDTH, $urandom_range(2, 1024));
      set_reg(CSR_MAP_HEIGHT, $urandom_range(2, 1024));
      set_reg(CSR_INV_SCALE_X, $urandom_range(1, 65536));
      set_reg(CSR_INV_SCALE_Z, $urandom_range(1, 65536));
      random_words(80);

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
